// ----- src/pft_pkg.sv -----
`default_nettype none
package pft_pkg;

  typedef enum logic [2:0] {
    OP_STEP    = 3'd0,
    OP_DUMP    = 3'd1,
    OP_REPORT  = 3'd2,
    OP_DELETE  = 3'd3,
    OP_REWRITE = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DUMP = 3'b010,
    ST_SCAN = 3'b100
  } seq_state_t;

  localparam int LAB_ROWS  = 8;
  localparam int START_IDX = 4;
  localparam int MAX_ROWS  = 8;

  // power-on table, index 0=A .. 7=H
  localparam logic [2:0] LAB_ZERO [LAB_ROWS] = '{3'd5, 3'd2, 3'd0, 3'd1,
                                                 3'd6, 3'd7, 3'd3, 3'd4};
  localparam logic [2:0] LAB_ONE  [LAB_ROWS] = '{3'd4, 3'd5, 3'd6, 3'd3,
                                                 3'd7, 3'd2, 3'd0, 3'd3};

endpackage
`default_nettype wire

// ----- src/pft_table.sv -----
`default_nettype none
// Transition table: one read port, one write port, loads the lab table on reset.
module pft_table #(
  parameter int NUM_STATES = 8,
  localparam int SW = $clog2(NUM_STATES)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [SW-1:0] rd_addr,
  output logic      [SW-1:0] rd_zero,
  output logic      [SW-1:0] rd_one,
  input  wire logic          wr_en,
  input  wire logic          wr_sel,
  input  wire logic [SW-1:0] wr_addr,
  input  wire logic [SW-1:0] wr_data
);

  logic [SW-1:0] zero_r [NUM_STATES];
  logic [SW-1:0] one_r  [NUM_STATES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_STATES; i++) begin
        // missing lab rows or out-of-range pointers become self loops
        if (i < pft_pkg::LAB_ROWS && int'(pft_pkg::LAB_ZERO[i[2:0]]) < NUM_STATES) begin
          zero_r[i] <= SW'(pft_pkg::LAB_ZERO[i[2:0]]);
        end else begin
          zero_r[i] <= SW'(i);
        end
        if (i < pft_pkg::LAB_ROWS && int'(pft_pkg::LAB_ONE[i[2:0]]) < NUM_STATES) begin
          one_r[i] <= SW'(pft_pkg::LAB_ONE[i[2:0]]);
        end else begin
          one_r[i] <= SW'(i);
        end
      end
    end else if (wr_en) begin
      if (wr_sel) begin
        one_r[wr_addr] <= wr_data;
      end else begin
        zero_r[wr_addr] <= wr_data;
      end
    end
  end

  assign rd_zero = zero_r[rd_addr];
  assign rd_one  = one_r[rd_addr];

endmodule
`default_nettype wire

// ----- src/programmable_fsm_table_with_pruning.sv -----
`default_nettype none
// Channel   Handshake          Ports
// -------   ----------------   ----------------------------------------------
// command   start / busy       in_opcode, in_input_bit, in_target_state
// result    out_valid strobe   out_state_index, out_next_zero, out_next_one,
//                              out_row_live, out_state_mask, out_none_found,
//                              out_last
//
// A word is taken when start is high and busy is low. Step and rewrite do
// not raise busy; a step's result shows on the next cycle. Dump emits
// min(NUM_STATES,8) rows, one row per cycle, and holds busy. Report and
// delete walk the table entry by entry through its single read port and
// emit one word after the last entry. Results are strobed for one cycle;
// the receiver cannot stall. rst_n is synchronous, reloads the lab table.
module programmable_fsm_table_with_pruning #(
  parameter int NUM_STATES = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] in_opcode,
  input  wire logic       in_input_bit,
  input  wire logic [2:0] in_target_state,
  output logic            out_valid,
  output logic      [2:0] out_state_index,
  output logic      [2:0] out_next_zero,
  output logic      [2:0] out_next_one,
  output logic            out_row_live,
  output logic      [7:0] out_state_mask,
  output logic            out_none_found,
  output logic            out_last
);

  localparam int SW = $clog2(NUM_STATES);
  localparam int NROWS = (NUM_STATES < pft_pkg::MAX_ROWS) ? NUM_STATES : pft_pkg::MAX_ROWS;
  localparam logic [SW-1:0] START_ST =
    SW'((pft_pkg::START_IDX < NUM_STATES) ? pft_pkg::START_IDX : NUM_STATES - 1);
  localparam logic [NUM_STATES-1:0] ALL_MASK = {NUM_STATES{1'b1}};

  pft_pkg::seq_state_t state_r, state_nxt;
  logic [SW-1:0]         cur_r, cur_nxt;
  logic [SW-1:0]         cnt_r, cnt_nxt;
  logic [NUM_STATES-1:0] del_r, del_nxt;
  logic [NUM_STATES-1:0] acc_r, acc_nxt;
  logic                  is_del_r, is_del_nxt;

  logic       ov_r, ov_nxt;
  logic [2:0] idx_r, idx_nxt, n0_r, n0_nxt, n1_r, n1_nxt;
  logic       live_r, live_nxt, none_r, none_nxt, last_r, last_nxt;
  logic [7:0] mask_r, mask_nxt;

  logic [SW-1:0]         rd_addr, rd_zero, rd_one;
  logic                  wr_en;
  logic [NUM_STATES-1:0] unref;
  logic                  accept;

  pft_table #(.NUM_STATES(NUM_STATES)) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .rd_zero (rd_zero),
    .rd_one  (rd_one),
    .wr_en   (wr_en),
    .wr_sel  (in_input_bit),
    .wr_addr (cur_r),
    .wr_data (SW'(in_target_state))
  );

  assign busy   = (state_r != pft_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign rd_addr = (state_r == pft_pkg::ST_IDLE) ? cur_r : cnt_r;
  assign wr_en  = accept && (in_opcode == pft_pkg::OP_REWRITE) &&
                  (int'(in_target_state) < NUM_STATES);

  // in a scan, live rows mark their two successors as referenced
  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    cnt_nxt    = cnt_r;
    del_nxt    = del_r;
    acc_nxt    = acc_r;
    is_del_nxt = is_del_r;
    ov_nxt     = 1'b0;
    idx_nxt    = '0;
    n0_nxt     = '0;
    n1_nxt     = '0;
    live_nxt   = 1'b0;
    mask_nxt   = '0;
    none_nxt   = 1'b0;
    last_nxt   = 1'b0;
    unref      = '0;
    unique case (state_r)
      pft_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_opcode)
            pft_pkg::OP_STEP: begin
              cur_nxt  = in_input_bit ? rd_one : rd_zero;
              ov_nxt   = 1'b1;
              idx_nxt  = 3'(cur_nxt);
              last_nxt = 1'b1;
            end
            pft_pkg::OP_DUMP: begin
              cnt_nxt   = '0;
              state_nxt = pft_pkg::ST_DUMP;
            end
            pft_pkg::OP_REPORT, pft_pkg::OP_DELETE: begin
              cnt_nxt    = '0;
              acc_nxt    = '0;
              is_del_nxt = (in_opcode == pft_pkg::OP_DELETE);
              state_nxt  = pft_pkg::ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      pft_pkg::ST_DUMP: begin
        ov_nxt   = 1'b1;
        idx_nxt  = 3'(cnt_r);
        n0_nxt   = 3'(rd_zero);
        n1_nxt   = 3'(rd_one);
        live_nxt = !del_r[cnt_r];
        if (cnt_r == SW'(NROWS - 1)) begin
          last_nxt  = 1'b1;
          state_nxt = pft_pkg::ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      pft_pkg::ST_SCAN: begin
        if (!del_r[cnt_r]) begin
          acc_nxt = acc_r | (NUM_STATES'(1) << rd_zero) | (NUM_STATES'(1) << rd_one);
        end
        if (cnt_r == SW'(NUM_STATES - 1)) begin
          unref     = ~acc_nxt & ~del_r & ALL_MASK;
          ov_nxt    = 1'b1;
          mask_nxt  = 8'(unref);
          none_nxt  = (unref == '0);
          last_nxt  = 1'b1;
          if (is_del_r) begin
            del_nxt = del_r | unref;
          end
          state_nxt = pft_pkg::ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = pft_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pft_pkg::ST_IDLE;
      cur_r   <= START_ST;
      del_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      del_r   <= del_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    acc_r    <= acc_nxt;
    is_del_r <= is_del_nxt;
    idx_r    <= idx_nxt;
    n0_r     <= n0_nxt;
    n1_r     <= n1_nxt;
    live_r   <= live_nxt;
    mask_r   <= mask_nxt;
    none_r   <= none_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid       = ov_r;
  assign out_state_index = idx_r;
  assign out_next_zero   = n0_r;
  assign out_next_one    = n1_r;
  assign out_row_live    = live_r;
  assign out_state_mask  = mask_r;
  assign out_none_found  = none_r;
  assign out_last        = last_r;

  a_dump_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pft_pkg::ST_DUMP) |=> out_valid)
    else $error("dump cycle without a row");

  a_rows_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> out_valid)
    else $error("gap inside a multi-word result");

  a_deleted_grows: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ((del_r & $past(del_r)) == $past(del_r)))
    else $error("deleted state came back to life");

  a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pft_pkg::ST_SCAN && cnt_r != SW'(NUM_STATES - 1)) |=> busy)
    else $error("scan ended early");

endmodule
`default_nettype wire

// ----- bench/pft_result_checker.sv -----
`default_nettype none
module pft_result_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic       busy,
  input  wire logic [2:0] in_opcode,
  input  wire logic       in_input_bit,
  input  wire logic [2:0] in_target_state,
  input  wire logic       out_valid,
  input  wire logic [2:0] out_state_index,
  input  wire logic [2:0] out_next_zero,
  input  wire logic [2:0] out_next_one,
  input  wire logic       out_row_live,
  input  wire logic [7:0] out_state_mask,
  input  wire logic       out_none_found,
  input  wire logic       out_last,
  output int              errors,
  output int              pending,
  output int              words_checked,
  output logic [7:0]      pruned
);

  typedef struct packed {
    logic [2:0] idx;
    logic [2:0] nz;
    logic [2:0] no;
    logic       live;
    logic [7:0] mask;
    logic       none;
    logic       last;
  } result_word_t;

  // shadow of the machine
  logic [2:0]   cur;
  logic [2:0]   nxt_zero [pft_pkg::MAX_ROWS];
  logic [2:0]   nxt_one  [pft_pkg::MAX_ROWS];
  logic [7:0]   gone;
  result_word_t expected_words [$];

  function automatic logic [7:0] unreferenced_states();
    logic [7:0] refd;
    refd = '0;
    for (int i = 0; i < pft_pkg::MAX_ROWS; i++) begin
      if (!gone[i]) begin
        refd[nxt_zero[i]] = 1'b1;
        refd[nxt_one[i]]  = 1'b1;
      end
    end
    return ~refd & ~gone;
  endfunction

  task automatic run_command(input logic [2:0] op, input logic sel, input logic [2:0] tgt);
    result_word_t w;
    logic [7:0]   unref;
    w = '0;
    case (op)
      pft_pkg::OP_STEP: begin
        cur = sel ? nxt_one[cur] : nxt_zero[cur];
        w.idx  = cur;
        w.last = 1'b1;
        expected_words.push_back(w);
      end
      pft_pkg::OP_DUMP: begin
        for (int k = 0; k < pft_pkg::MAX_ROWS; k++) begin
          w.idx  = 3'(k);
          w.nz   = nxt_zero[k];
          w.no   = nxt_one[k];
          w.live = ~gone[k];
          w.last = (k == pft_pkg::MAX_ROWS - 1);
          expected_words.push_back(w);
        end
      end
      pft_pkg::OP_REPORT, pft_pkg::OP_DELETE: begin
        unref = unreferenced_states();
        if (op == pft_pkg::OP_DELETE) gone = gone | unref;
        w.mask = unref;
        w.none = (unref == '0);
        w.last = 1'b1;
        expected_words.push_back(w);
      end
      pft_pkg::OP_REWRITE: begin
        if (sel) nxt_one[cur] = tgt;
        else nxt_zero[cur] = tgt;
      end
      default: ;  // unused opcodes do nothing
    endcase
  endtask

  always @(posedge clk) begin : watch
    result_word_t got;
    result_word_t want;
    if (!rst_n) begin
      cur = 3'(pft_pkg::START_IDX);
      for (int i = 0; i < pft_pkg::MAX_ROWS; i++) begin
        nxt_zero[i] = pft_pkg::LAB_ZERO[i];
        nxt_one[i]  = pft_pkg::LAB_ONE[i];
      end
      gone = '0;
      expected_words.delete();
      errors        <= 0;
      words_checked <= 0;
    end else begin
      // compare before taking the new word; its results come later
      if (out_valid) begin
        got = '{out_state_index, out_next_zero, out_next_one, out_row_live,
                out_state_mask, out_none_found, out_last};
        words_checked <= words_checked + 1;
        if (expected_words.size() == 0) begin
          if (errors < 10) begin
            $display("[%0t] unexpected result word", $realtime);
            $display("  actual   idx=%0d n0=%0d n1=%0d live=%b mask=%h none=%b last=%b",
                     got.idx, got.nz, got.no, got.live, got.mask, got.none, got.last);
          end
          errors <= errors + 1;
        end else begin
          want = expected_words.pop_front();
          if (got.idx !== want.idx || got.nz !== want.nz || got.no !== want.no ||
              got.live !== want.live || got.mask !== want.mask ||
              got.none !== want.none || got.last !== want.last) begin
            if (errors < 10) begin
              $display("[%0t] result mismatch", $realtime);
              $display("  expected idx=%0d n0=%0d n1=%0d live=%b mask=%h none=%b last=%b",
                       want.idx, want.nz, want.no, want.live, want.mask, want.none, want.last);
              $display("  actual   idx=%0d n0=%0d n1=%0d live=%b mask=%h none=%b last=%b",
                       got.idx, got.nz, got.no, got.live, got.mask, got.none, got.last);
            end
            errors <= errors + 1;
          end
        end
      end
      if (start && !busy) run_command(in_opcode, in_input_bit, in_target_state);
    end
    pending <= expected_words.size();
    pruned  <= gone;
  end

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
`default_nettype none
module tb_top;

  localparam int          CYCLE_LIMIT   = 60000;
  localparam int          DRAIN_CYCLES  = 24;
  localparam int          RANDOM_WORDS  = 76;
  localparam logic [2:0]  OP_UNUSED_LO  = 3'd5;
  localparam logic [2:0]  OP_UNUSED_HI  = 3'd7;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [2:0] in_opcode;
  logic       in_input_bit;
  logic [2:0] in_target_state;
  logic       out_valid;
  logic [2:0] out_state_index;
  logic [2:0] out_next_zero;
  logic [2:0] out_next_one;
  logic       out_row_live;
  logic [7:0] out_state_mask;
  logic       out_none_found;
  logic       out_last;

  int         errors;
  int         pending;
  int         words_checked;
  logic [7:0] pruned;

  int         cycles = 0;
  int         sent;
  int         op_seen [8];

  programmable_fsm_table_with_pruning dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_input_bit(in_input_bit),
    .in_target_state(in_target_state),
    .out_valid(out_valid), .out_state_index(out_state_index),
    .out_next_zero(out_next_zero), .out_next_one(out_next_one),
    .out_row_live(out_row_live), .out_state_mask(out_state_mask),
    .out_none_found(out_none_found), .out_last(out_last)
  );

  pft_result_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_input_bit(in_input_bit),
    .in_target_state(in_target_state),
    .out_valid(out_valid), .out_state_index(out_state_index),
    .out_next_zero(out_next_zero), .out_next_one(out_next_one),
    .out_row_live(out_row_live), .out_state_mask(out_state_mask),
    .out_none_found(out_none_found), .out_last(out_last),
    .errors(errors), .pending(pending), .words_checked(words_checked),
    .pruned(pruned)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("programmable_fsm_table_with_pruning test failed");
      $finish;
    end
  end

  // called right after a posedge; returns at the posedge that takes the word
  task automatic send(input logic [2:0] op, input logic sel, input logic [2:0] tgt);
    int gap;
    // every third run of a dozen words goes back to back
    gap = ((sent / 12) % 3 == 0) ? 0 : $urandom_range(0, 14);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start           <= 1'b1;
    in_opcode       <= op;
    in_input_bit    <= sel;
    in_target_state <= tgt;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sent++;
    op_seen[op]++;
  endtask

  task automatic send_random(input logic [2:0] op);
    send(op, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
  endtask

  initial begin : stimulus
    int useful;
    int r;
    sent            = 0;
    for (int i = 0; i < 8; i++) op_seen[i] = 0;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_opcode       = pft_pkg::OP_STEP;
    in_input_bit    = 1'b0;
    in_target_state = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // power-on table: everything is referenced
    send(pft_pkg::OP_DUMP,    1'b0, 3'd0);
    send(pft_pkg::OP_REPORT,  1'b0, 3'd0);
    send(pft_pkg::OP_STEP,    1'b0, 3'd0);
    send(pft_pkg::OP_STEP,    1'b1, 3'd0);
    // route A and H away from E so E drops out
    send(pft_pkg::OP_REWRITE, 1'b1, 3'd7);
    send(pft_pkg::OP_STEP,    1'b1, 3'd0);
    send(pft_pkg::OP_REWRITE, 1'b0, 3'd7);
    send(pft_pkg::OP_REPORT,  1'b1, 3'd7);
    send(pft_pkg::OP_DELETE,  1'b0, 3'd0);
    send(pft_pkg::OP_REPORT,  1'b0, 3'd0);
    send(pft_pkg::OP_DUMP,    1'b1, 3'd7);
    // step into the deleted state and back out of it
    send(pft_pkg::OP_STEP,    1'b1, 3'd0);
    send(pft_pkg::OP_REWRITE, 1'b0, 3'd4);
    send(pft_pkg::OP_STEP,    1'b0, 3'd0);
    send(pft_pkg::OP_STEP,    1'b0, 3'd0);
    send(pft_pkg::OP_REWRITE, 1'b1, 3'd7);
    send(pft_pkg::OP_REWRITE, 1'b0, 3'd0);
    for (logic [3:0] op = 4'(OP_UNUSED_LO); op <= 4'(OP_UNUSED_HI); op++)
      send_random(op[2:0]);
    send(pft_pkg::OP_DELETE,  1'b1, 3'd0);
    send(pft_pkg::OP_STEP,    1'b1, 3'd7);
    send(pft_pkg::OP_DUMP,    1'b0, 3'd0);

    useful = 0;
    while (useful < RANDOM_WORDS) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        send_random(pft_pkg::OP_STEP);
        useful++;
      end else if (r < 60) begin
        send_random(pft_pkg::OP_REWRITE);
        useful++;
      end else if (r < 67) begin
        send_random(pft_pkg::OP_DUMP);
        useful++;
      end else if (r < 77) begin
        send_random(pft_pkg::OP_REPORT);
        useful++;
      end else if (r < 86) begin
        send_random(pft_pkg::OP_DELETE);
        useful++;
      end else if (r < 90) begin
        send_random(3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)));
      end else begin
        // prune pass: look, cut, look again, then show the table
        send_random(pft_pkg::OP_REPORT);
        send_random(pft_pkg::OP_DELETE);
        send_random(pft_pkg::OP_REPORT);
        send_random(pft_pkg::OP_DUMP);
        useful += 4;
      end
    end
    @(negedge clk);
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d words sent: %0d step, %0d dump, %0d report, %0d delete, %0d rewrite",
             sent, op_seen[pft_pkg::OP_STEP], op_seen[pft_pkg::OP_DUMP],
             op_seen[pft_pkg::OP_REPORT], op_seen[pft_pkg::OP_DELETE],
             op_seen[pft_pkg::OP_REWRITE]);
    $display("%0d unused, %0d result words checked, %0d mismatches, pruned state mask %b",
             op_seen[5] + op_seen[6] + op_seen[7], words_checked, errors, pruned);
    if (errors == 0 && pending == 0)
      $display("programmable_fsm_table_with_pruning test passed");
    else
      $display("programmable_fsm_table_with_pruning test failed");
    $finish;
  end

endmodule
`default_nettype wire
